FILE: rtl/xtea_head_lfsr_stream_cipher_core_macros.svh
// assertion macros used by the cipher core controller
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef XTEA_HEAD_LFSR_STREAM_CIPHER_CORE_MACROS_SVH
`define XTEA_HEAD_LFSR_STREAM_CIPHER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define XHL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define XHL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/xhl_pkg.sv
// shared types and constants of the xtea head / lfsr stream cipher core
// no dependencies
`timescale 1ns / 1ps

package xhl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CYC_W      = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_MAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_ALT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_FETCH = 3'd6;

    localparam logic [CYC_W-1:0] CYCLES_RESET = 8'd32;

    // controller to datapath
    typedef struct packed {
        logic       head_wr;
        logic [2:0] head_idx;
        logic       init;
        logic       round;
        logic       half;
        logic       seed;
        logic       stream;
        logic       emit;
        logic [2:0] emit_idx;
        logic       out_last;
        logic       out_end;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CYC_W-1:0] cycles;
        logic             dir;
    } t_stat;

endpackage

FILE: rtl/xhl_in_if.sv
// input channel: one message word with its framing marks
// no dependencies
`timescale 1ns / 1ps

interface xhl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       first_of_message;
    logic       last_of_message;

    modport source (output valid, output data_in, output first_of_message,
                    output last_of_message, input ready);
    modport sink   (input valid, input data_in, input first_of_message,
                    input last_of_message, output ready);
endinterface

FILE: rtl/xhl_out_if.sv
// output channel: one transformed word with its marks
// no dependencies
`timescale 1ns / 1ps

interface xhl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output data_out, output run_last,
                    output message_end, input ready);
    modport sink   (input valid, input data_out, input run_last,
                    input message_end, output ready);
endinterface

FILE: rtl/xhl_ctrl.sv
// controller: message framing, round sequencing, head emission
// depends on xhl_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "xtea_head_lfsr_stream_cipher_core_macros.svh"

module xhl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_in_first,
    input  logic          i_in_last,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  xhl_pkg::t_stat i_stat,
    output xhl_pkg::t_cmd  o_cmd
);
    import xhl_pkg::*;

    localparam logic [1:0] ST_IN   = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [3:0]       r_pos, n_pos;
    logic [CYC_W-1:0] r_cyc, n_cyc;
    logic             r_half, n_half;
    logic [2:0]       r_emit, n_emit;
    logic             r_last, n_last;
    logic             r_out_valid, n_out_valid;

    logic       slot_free;
    logic       accept;
    logic [3:0] eff_pos;
    logic       seed_now;
    t_cmd       cmd;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IN) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign eff_pos    = i_in_first ? 4'd0 : r_pos;

    // seed after the third encrypt cycle, or with three decrypt cycles left
    assign seed_now = r_half &&
        ((!i_stat.dir && (r_cyc == 8'd2)) ||
         (i_stat.dir && (i_stat.cycles >= 8'd4) && (r_cyc == i_stat.cycles - 8'd4)));

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cyc       = r_cyc;
        n_half      = r_half;
        n_emit      = r_emit;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        cmd = '0;

        unique case (r_state)
            ST_IN: begin
                if (accept) begin
                    if (eff_pos[3]) begin
                        cmd.stream   = 1'b1;
                        cmd.out_last = 1'b1;
                        cmd.out_end  = i_in_last;
                        n_out_valid  = 1'b1;
                        n_pos        = i_in_last ? 4'd0 : 4'd8;
                    end else begin
                        cmd.head_wr  = 1'b1;
                        cmd.head_idx = eff_pos[2:0];
                        if (eff_pos == 4'd7) begin
                            cmd.init = 1'b1;
                            n_last   = i_in_last;
                            n_cyc    = '0;
                            n_half   = 1'b0;
                            n_emit   = 3'd0;
                            n_pos    = 4'd7;
                            n_state  = (i_stat.cycles == '0) ? ST_EMIT : ST_RUN;
                        end else begin
                            n_pos = i_in_last ? 4'd0 : eff_pos + 4'd1;
                        end
                    end
                end
            end
            ST_RUN: begin
                cmd.round = 1'b1;
                cmd.half  = r_half;
                cmd.seed  = seed_now;
                n_half    = !r_half;
                if (r_half) begin
                    if (r_cyc == i_stat.cycles - 8'd1) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_cyc = r_cyc + 8'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_idx = r_emit;
                    cmd.out_last = (r_emit == 3'd7);
                    cmd.out_end  = (r_emit == 3'd7) && r_last;
                    n_out_valid  = 1'b1;
                    n_emit       = r_emit + 3'd1;
                    if (r_emit == 3'd7) begin
                        n_state = ST_IN;
                        n_pos   = r_last ? 4'd0 : 4'd8;
                    end
                end
            end
            default: begin
                n_state = ST_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IN;
            r_pos       <= '0;
            r_cyc       <= '0;
            r_half      <= 1'b0;
            r_emit      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cyc       <= n_cyc;
            r_half      <= n_half;
            r_emit      <= n_emit;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    `XHL_ASSERT_SAME(a_pos_range, 1'b1, r_pos <= 4'd8, "byte position out of range")
    `XHL_ASSERT_NEXT(a_emit_start, r_state != ST_EMIT, (r_state != ST_EMIT) || (r_emit == 3'd0), "emit does not start at word zero")
    `XHL_ASSERT_SAME(a_no_overwrite, r_out_valid && !i_out_ready, !cmd.stream && !cmd.emit, "output register overwritten while stalled")
    `XHL_ASSERT_SAME(a_cyc_bound, r_state == ST_RUN, r_cyc < i_stat.cycles, "round counter beyond cycle count")

endmodule

FILE: rtl/xhl_dp.sv
// datapath: configuration registers, block register with shared xtea round,
// lfsr keystream generator and output register; depends on xhl_pkg
`timescale 1ns / 1ps

module xhl_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [xhl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [xhl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  xhl_pkg::t_cmd                     i_cmd,
    output xhl_pkg::t_stat                    o_stat,
    input  logic [7:0]                        i_data_in,
    output logic [7:0]                        o_data_out,
    output logic                              o_run_last,
    output logic                              o_message_end
);
    import xhl_pkg::*;

    localparam logic [31:0] DELTA = 32'h9E3779B9;

    logic [63:0]      r_key_low, r_key_high;
    logic [CYC_W-1:0] r_cycles;
    logic             r_dir;
    logic [31:0]      r_poly_main, r_poly_alt;
    logic [15:0]      r_poly_fetch;

    logic [31:0] r_v0, n_v0, r_v1, n_v1;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_lfsr, n_lfsr;
    logic [15:0] r_fetch, n_fetch;
    logic [7:0]  r_out_data, n_out_data;
    logic        r_out_last, r_out_end;

    // round operands
    logic        upd_v1;
    logic [31:0] src, tgt, kword, fmix, mval, res;
    logic [1:0]  ksel;

    // keystream
    logic [31:0] poly, s_next;
    logic [15:0] f_next;
    logic [7:0]  b0, b1, b2, b3, ks;
    logic [31:0] emit_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_cycles     <= CYCLES_RESET;
            r_dir        <= 1'b0;
            r_poly_main  <= '0;
            r_poly_alt   <= '0;
            r_poly_fetch <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                CFG_CYCLES:     r_cycles     <= i_cfg_data[CYC_W-1:0];
                CFG_DIRECTION:  r_dir        <= i_cfg_data[0];
                CFG_POLY_MAIN:  r_poly_main  <= i_cfg_data[31:0];
                CFG_POLY_ALT:   r_poly_alt   <= i_cfg_data[31:0];
                CFG_POLY_FETCH: r_poly_fetch <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_stat.cycles = r_cycles;
    assign o_stat.dir    = r_dir;

    // half round: which word moves depends on direction and half
    assign upd_v1 = i_cmd.half ^ r_dir;
    assign src    = upd_v1 ? r_v0 : r_v1;
    assign tgt    = upd_v1 ? r_v1 : r_v0;
    assign ksel   = upd_v1 ? r_sum[12:11] : r_sum[1:0];

    always_comb begin
        unique case (ksel)
            2'd0: kword = r_key_low[31:0];
            2'd1: kword = r_key_low[63:32];
            2'd2: kword = r_key_high[31:0];
            2'd3: kword = r_key_high[63:32];
            default: kword = '0;
        endcase
    end

    assign fmix = ((src << 4) ^ (src >> 5)) + src;
    assign mval = fmix ^ (r_sum + kword);
    assign res  = r_dir ? (tgt - mval) : (tgt + mval);

    // lfsr and fetch register step
    assign poly   = ((r_fetch & 16'h0410) == 16'h0400) ? r_poly_main : r_poly_alt;
    assign s_next = r_lfsr[0] ? (((r_lfsr ^ poly) >> 1) | 32'h8000_0000) : (r_lfsr >> 1);
    assign f_next = r_fetch[0] ? ((r_fetch << 1) ^ r_poly_fetch) : ((r_fetch << 1) | 16'h0001);

    assign b0 = s_next[7:0];
    assign b1 = s_next[15:8];
    assign b2 = s_next[23:16];
    assign b3 = s_next[31:24];

    always_comb begin
        unique case (f_next[2:0])
            3'd0: ks = (b2 >> 3) | (~b0 & 8'hE0);
            3'd1: ks = b1 ^ b3;
            3'd2: ks = (~b0) ^ (b1 + 8'h15);
            3'd3: ks = b1 + b2 + 8'h40;
            3'd4: ks = (b0 << 4) | (b3 >> 4);
            3'd5: ks = b3 + ((~b2) ^ 8'hA6);
            3'd6: ks = (~b0) ^ (b2 + 8'h81);
            3'd7: ks = b1 + (~b3) + 8'd5;
            default: ks = '0;
        endcase
    end

    assign emit_word = i_cmd.emit_idx[2] ? r_v1 : r_v0;

    always_comb begin
        n_v0       = r_v0;
        n_v1       = r_v1;
        n_sum      = r_sum;
        n_lfsr     = r_lfsr;
        n_fetch    = r_fetch;
        n_out_data = r_out_data;

        // head words land straight in their block lanes, little-endian
        if (i_cmd.head_wr) begin
            if (i_cmd.head_idx[2]) begin
                n_v1[8*i_cmd.head_idx[1:0] +: 8] = i_data_in;
            end else begin
                n_v0[8*i_cmd.head_idx[1:0] +: 8] = i_data_in;
            end
        end
        if (i_cmd.init) begin
            n_sum = r_dir ? 32'(DELTA * 32'(r_cycles)) : 32'd0;
        end
        if (i_cmd.round) begin
            if (upd_v1) begin
                n_v1 = res;
            end else begin
                n_v0 = res;
            end
            if (!i_cmd.half) begin
                n_sum = r_dir ? (r_sum - DELTA) : (r_sum + DELTA);
            end
        end
        if (i_cmd.seed) begin
            n_lfsr  = (n_v0 ^ n_v1) | 32'h0000_0040;
            n_fetch = n_v0[20:5] | 16'h0020;
        end
        if (i_cmd.stream) begin
            n_lfsr     = s_next;
            n_fetch    = f_next;
            n_out_data = i_data_in ^ ks;
        end
        if (i_cmd.emit) begin
            n_out_data = emit_word[8*i_cmd.emit_idx[1:0] +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= '0;
            r_fetch <= '0;
        end else begin
            r_lfsr  <= n_lfsr;
            r_fetch <= n_fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0       <= n_v0;
        r_v1       <= n_v1;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
        if (i_cmd.stream || i_cmd.emit) begin
            r_out_last <= i_cmd.out_last;
            r_out_end  <= i_cmd.out_end;
        end
    end

    assign o_data_out    = r_out_data;
    assign o_run_last    = r_out_last;
    assign o_message_end = r_out_end;

endmodule

FILE: rtl/xtea_head_lfsr_stream_cipher_core.sv
// stream word: result in the cycle after acceptance, one word per cycle as the output drains
// head: words 0..6 taken one per cycle while the output is free, no result; the eighth starts
// two half rounds per cycle_count on the one shared round adder, then eight head words leave
// one per cycle as the output drains; the next input word is taken once the last head word
// has left the output register; reset: synchronous, active low; registers to defaults
// (cycle_count 32), lfsr, fetch and byte position to zero, no clearing pass
`timescale 1ns / 1ps

module xtea_head_lfsr_stream_cipher_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    xhl_in_if.sink                         i_in_ch,
    xhl_out_if.source                      o_out_ch,
    input  logic                           i_cfg_we,
    input  logic [xhl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [xhl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import xhl_pkg::*;

    // command and status between controller and datapath
    t_cmd  cmd;
    t_stat stat;

    // controller: framing of the message, round count, head word order
    xhl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .i_in_first  (i_in_ch.first_of_message),
        .i_in_last   (i_in_ch.last_of_message),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: block cipher rounds, keystream, output word register
    xhl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_data_in     (i_in_ch.data_in),
        .o_data_out    (o_out_ch.data_out),
        .o_run_last    (o_out_ch.run_last),
        .o_message_end (o_out_ch.message_end)
    );

endmodule

FILE: sim/xhl_cipher_checker.sv
// checker for the xtea head / lfsr stream cipher core: watches both channels and
// the register write port, predicts every output word and compares in order
// depends on xhl_pkg, xhl_in_if and xhl_out_if
`timescale 1ns / 1ps

module xhl_cipher_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    xhl_in_if                              i_in_mon,
    xhl_out_if                             i_out_mon,
    input  logic                           i_cfg_we,
    input  logic [xhl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [xhl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_heads,
    output int                             o_stream_words
);
    import xhl_pkg::*;

    localparam logic [31:0] XTEA_DELTA    = 32'h9E37_79B9;
    localparam logic [15:0] MAIN_SEL_MASK = 16'h0410;
    localparam logic [15:0] MAIN_SEL_VAL  = 16'h0400;
    localparam logic [31:0] LFSR_TOP      = 32'h8000_0000;
    localparam logic [31:0] SEED_SET      = 32'h0000_0040;
    localparam logic [31:0] FETCH_SET     = 32'h0000_0020;
    localparam int          HEAD_LEN      = 8;
    localparam int          SEED_CYCLES   = 3;
    localparam int          MAX_REPORTS   = 10;

    // byte mixes picked by the low fetch bits
    typedef enum logic [2:0] {
        MIX_SHIFT_MASK,
        MIX_XOR_OUTER,
        MIX_INV_ADD_LOW,
        MIX_SUM_MID,
        MIX_NIBBLE,
        MIX_ADD_INV_HIGH,
        MIX_INV_ADD_HIGH,
        MIX_ADD_INV_OUTER
    } t_mix;

    typedef struct packed {
        logic [7:0] data_out;
        logic       run_last;
        logic       message_end;
    } t_word;

    logic [63:0] key_lo, key_hi;
    logic [7:0]  n_cycles;
    logic        decrypt;
    logic [31:0] poly_main, poly_alt;
    logic [15:0] poly_fetch;

    logic [7:0]  head_buf [HEAD_LEN];
    logic [3:0]  byte_pos;
    logic [31:0] lfsr;
    logic [15:0] fetch;

    t_word due_words [$];

    function automatic logic [31:0] feistel(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    task automatic seed_stream(input logic [31:0] v0, input logic [31:0] v1);
        logic [31:0] f;
        f = (v0 >> 5) | FETCH_SET;
        lfsr  = (v0 ^ v1) | SEED_SET;
        fetch = f[15:0];
    endtask

    function automatic logic [7:0] next_keystream_byte();
        logic [31:0] poly;
        logic [7:0]  b0, b1, b2, b3, r;
        // polynomial follows the fetch value from before the step
        poly  = ((fetch & MAIN_SEL_MASK) == MAIN_SEL_VAL) ? poly_main : poly_alt;
        lfsr  = lfsr[0] ? (((lfsr ^ poly) >> 1) | LFSR_TOP) : (lfsr >> 1);
        fetch = fetch[0] ? ((fetch << 1) ^ poly_fetch) : ((fetch << 1) | 16'h0001);
        {b3, b2, b1, b0} = lfsr;
        case (t_mix'(fetch[2:0]))
            MIX_SHIFT_MASK:    r = (b2 >> 3) | (~b0 & 8'hE0);
            MIX_XOR_OUTER:     r = b1 ^ b3;
            MIX_INV_ADD_LOW:   r = (~b0) ^ (b1 + 8'h15);
            MIX_SUM_MID:       r = b1 + b2 + 8'h40;
            MIX_NIBBLE:        r = (b0 << 4) | (b3 >> 4);
            MIX_ADD_INV_HIGH:  r = b3 + ((~b2) ^ 8'hA6);
            MIX_INV_ADD_HIGH:  r = (~b0) ^ (b2 + 8'h81);
            MIX_ADD_INV_OUTER: r = b1 + (~b3) + 8'h05;
        endcase
        return r;
    endfunction

    task automatic run_head_block();
        logic [31:0] kw [4];
        logic [31:0] v0, v1, delta_sum;
        int n;
        kw[0] = key_lo[31:0];
        kw[1] = key_lo[63:32];
        kw[2] = key_hi[31:0];
        kw[3] = key_hi[63:32];
        v0 = {head_buf[3], head_buf[2], head_buf[1], head_buf[0]};
        v1 = {head_buf[7], head_buf[6], head_buf[5], head_buf[4]};
        n = n_cycles;
        if (!decrypt) begin
            delta_sum = '0;
            for (int i = 0; i < n; i++) begin
                v0 += feistel(v1) ^ (delta_sum + kw[delta_sum[1:0]]);
                delta_sum += XTEA_DELTA;
                v1 += feistel(v0) ^ (delta_sum + kw[delta_sum[12:11]]);
                if (i == SEED_CYCLES - 1) seed_stream(v0, v1);
            end
        end else begin
            delta_sum = XTEA_DELTA * n_cycles;
            for (int i = 0; i < n; i++) begin
                v1 -= feistel(v0) ^ (delta_sum + kw[delta_sum[12:11]]);
                delta_sum -= XTEA_DELTA;
                v0 -= feistel(v1) ^ (delta_sum + kw[delta_sum[1:0]]);
                // seed when the cycles still to go number SEED_CYCLES
                if (n > SEED_CYCLES && i == n - SEED_CYCLES - 1) seed_stream(v0, v1);
            end
        end
        {head_buf[3], head_buf[2], head_buf[1], head_buf[0]} = v0;
        {head_buf[7], head_buf[6], head_buf[5], head_buf[4]} = v1;
    endtask

    task automatic transform_word(input logic [7:0] d, input logic first, input logic last);
        if (first || byte_pos > 4'd8) byte_pos = '0;
        if (byte_pos >= 4'd8) begin
            due_words.push_back(t_word'{d ^ next_keystream_byte(), 1'b1, last});
            o_stream_words++;
            if (last) byte_pos = '0;
        end else begin
            head_buf[byte_pos[2:0]] = d;
            byte_pos++;
            if (byte_pos == 4'd8) begin
                run_head_block();
                o_heads++;
                for (int i = 0; i < HEAD_LEN; i++) begin
                    due_words.push_back(t_word'{head_buf[i], i == HEAD_LEN - 1,
                                                i == HEAD_LEN - 1 && last});
                end
                byte_pos = last ? 4'd0 : 4'd8;
            end else if (last) begin
                // short message, head thrown away
                byte_pos = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_word got, want;
        if (!i_rst_n) begin
            key_lo         = '0;
            key_hi         = '0;
            n_cycles       = CYCLES_RESET;
            decrypt        = 1'b0;
            poly_main      = '0;
            poly_alt       = '0;
            poly_fetch     = '0;
            byte_pos       = '0;
            lfsr           = '0;
            fetch          = '0;
            o_errors       = 0;
            o_heads        = 0;
            o_stream_words = 0;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_LOW:    key_lo     = i_cfg_data;
                    CFG_KEY_HIGH:   key_hi     = i_cfg_data;
                    CFG_CYCLES:     n_cycles   = i_cfg_data[7:0];
                    CFG_DIRECTION:  decrypt    = i_cfg_data[0];
                    CFG_POLY_MAIN:  poly_main  = i_cfg_data[31:0];
                    CFG_POLY_ALT:   poly_alt   = i_cfg_data[31:0];
                    CFG_POLY_FETCH: poly_fetch = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                transform_word(i_in_mon.data_in, i_in_mon.first_of_message,
                               i_in_mon.last_of_message);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = t_word'{i_out_mon.data_out, i_out_mon.run_last, i_out_mon.message_end};
                if (due_words.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected word data_out %02h run_last %0d",
                                 $realtime, got.data_out, got.run_last,
                                 " message_end %0d", got.message_end);
                    end
                end else begin
                    want = due_words.pop_front();
                    if (got != want) begin
                        o_errors++;
                        if (o_errors <= MAX_REPORTS) begin
                            $display("%0t: data_out exp %02h got %02h,",
                                     $realtime, want.data_out, got.data_out,
                                     " run_last exp %0d got %0d,",
                                     want.run_last, got.run_last,
                                     " message_end exp %0d got %0d",
                                     want.message_end, got.message_end);
                        end
                    end
                end
            end
        end
        o_pending = due_words.size();
    end

endmodule

FILE: sim/tb.sv
// top of the cipher core bench: clock, reset, register writes and message stimulus
// with random idling on both channels; checking lives in xhl_cipher_checker
// depends on xhl_pkg, xhl_in_if, xhl_out_if, the core and the checker
`timescale 1ns / 1ps

module tb;
    import xhl_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int DRAIN_CYCLES    = 32;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_WORDS     = 16;
    localparam int N_SETTINGS      = 10;
    localparam int HOLD_SETTING    = 6;
    localparam int N_DIRECTED      = 23;
    localparam int N_REGS          = 1 << CFG_IDX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    // directed words packed as {first, last, data}
    localparam logic [9:0] DIRECTED [N_DIRECTED] = '{
        // short message, dropped before the head fills
        {2'b10, 8'h12}, {2'b00, 8'h34}, {2'b01, 8'h56},
        // no start mark after a message end: head of extreme bytes plus one stream word
        {2'b00, 8'h00}, {2'b00, 8'hFF}, {2'b00, 8'h80}, {2'b00, 8'h01},
        {2'b00, 8'h7F}, {2'b00, 8'hAA}, {2'b00, 8'h55}, {2'b00, 8'hFE},
        {2'b01, 8'hFF},
        // two words, then abandoned by a new start mark
        {2'b10, 8'hC3}, {2'b00, 8'h3C},
        // full head whose eighth word ends the message
        {2'b10, 8'h01}, {2'b00, 8'h02}, {2'b00, 8'h04}, {2'b00, 8'h08},
        {2'b00, 8'h10}, {2'b00, 8'h20}, {2'b00, 8'h40}, {2'b01, 8'h80},
        // one word carrying both marks
        {2'b11, 8'hA5}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int errors, pending, heads, stream_words;
    int src_idle_pct, snk_idle_pct, hold_off_req;
    int words_sent, messages_sent;

    xhl_in_if  in_ch ();
    xhl_out_if out_ch ();

    xtea_head_lfsr_stream_cipher_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    xhl_cipher_checker cipher_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_heads        (heads),
        .o_stream_words (stream_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // hard stop in case the core hangs
    initial begin
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // offer one word at a falling edge, after random idle cycles, and hold it until taken;
    // returns at the falling edge after acceptance with valid still high
    task automatic drive_word(input logic [7:0] d, input logic first, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.data_in          <= d;
        in_ch.first_of_message <= first;
        in_ch.last_of_message  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // stop offering, let every expected word come out, then allow for words still in flight
    // that cause no output
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // receiver: random ready, or a long hold-off when requested
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req > 0) begin
                n = hold_off_req;
                hold_off_req = 0;
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] reg_val [N_REGS];
        logic [7:0] cyc;
        logic       dir;
        logic       mark_first, mark_last;
        int         kind, len, start_words;

        in_ch.valid            = 1'b0;
        in_ch.data_in          = '0;
        in_ch.first_of_message = 1'b0;
        in_ch.last_of_message  = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_KEY_LOW;
        i_cfg_data             = '0;
        src_idle_pct           = 19;
        snk_idle_pct           = 73;
        hold_off_req           = 0;
        words_sent             = 0;
        messages_sent          = 0;
        i_rst_n                = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words under the reset register values
        for (int i = 0; i < N_DIRECTED; i++) begin
            drive_word(DIRECTED[i][7:0], DIRECTED[i][9], DIRECTED[i][8]);
        end
        messages_sent += 5;

        for (int s = 0; s < N_SETTINGS; s++) begin
            wait_drained();

            // idling: sender light / receiver heavy, then swapped, then none
            if (s < 3) begin
                src_idle_pct = 19;
                snk_idle_pct = 73;
            end else if (s < 6) begin
                src_idle_pct = 73;
                snk_idle_pct = 19;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            // cycle counts straddle the seeding limits in both directions
            case (s)
                0:       begin cyc = 8'd255; dir = 1'b1; end
                1:       begin cyc = 8'd0;   dir = 1'b0; end
                2:       begin cyc = 8'd2;   dir = 1'b0; end
                3:       begin cyc = 8'd3;   dir = 1'b0; end
                4:       begin cyc = 8'd3;   dir = 1'b1; end
                5:       begin cyc = 8'd4;   dir = 1'b1; end
                6:       begin cyc = 8'd1;   dir = 1'b1; end
                7:       begin cyc = 8'd255; dir = 1'b0; end
                8:       begin cyc = 8'($urandom_range(64, 1));  dir = 1'($urandom_range(1)); end
                default: begin cyc = 8'($urandom_range(255, 1)); dir = 1'($urandom_range(1)); end
            endcase

            // junk above each register's width must be ignored
            reg_val[CFG_KEY_LOW]    = {$urandom, $urandom};
            reg_val[CFG_KEY_HIGH]   = {$urandom, $urandom};
            reg_val[CFG_CYCLES]     = {$urandom, 24'($urandom), cyc};
            reg_val[CFG_DIRECTION]  = {$urandom, 31'($urandom), dir};
            reg_val[CFG_POLY_MAIN]  = {$urandom, $urandom};
            reg_val[CFG_POLY_ALT]   = {$urandom, $urandom};
            reg_val[CFG_POLY_FETCH] = {$urandom, $urandom};
            reg_val[CFG_IDX_SPARE]  = {$urandom, $urandom};
            if (s == 0) begin
                reg_val[CFG_KEY_LOW]    = '1;
                reg_val[CFG_KEY_HIGH]   = '1;
                reg_val[CFG_POLY_MAIN]  = '1;
                reg_val[CFG_POLY_ALT]   = '1;
                reg_val[CFG_POLY_FETCH] = '1;
            end else if (s == 1) begin
                reg_val[CFG_POLY_MAIN]  = '0;
                reg_val[CFG_POLY_ALT]   = '0;
                reg_val[CFG_POLY_FETCH] = '0;
            end

            // one write per cycle, the spare index last
            for (int r = 0; r < N_REGS; r++) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= CFG_IDX_W'(r);
                i_cfg_data <= reg_val[r];
                @(negedge i_clk);
            end
            i_cfg_we <= 1'b0;

            // long receiver hold-off while the sender keeps pushing
            if (s == HOLD_SETTING) hold_off_req = HOLD_OFF_CYCLES;

            start_words = words_sent;
            while (words_sent - start_words < PHASE_WORDS) begin
                kind = $urandom_range(99);
                if (kind < 10) begin
                    // short message
                    len        = $urandom_range(7, 1);
                    mark_first = 1'b1;
                    mark_last  = 1'b1;
                end else if (kind < 18) begin
                    // cut off by the next start mark
                    len        = $urandom_range(11, 1);
                    mark_first = 1'b1;
                    mark_last  = 1'b0;
                end else if (kind < 26) begin
                    // no start mark on the opening word
                    len        = $urandom_range(20, 8);
                    mark_first = 1'b0;
                    mark_last  = 1'b1;
                end else begin
                    // well-formed, sometimes exactly one head long
                    len        = ($urandom_range(3) == 0) ? 8 : $urandom_range(24, 9);
                    mark_first = 1'b1;
                    mark_last  = 1'b1;
                end
                for (int j = 0; j < len; j++) begin
                    drive_word(8'($urandom_range(255)), mark_first && j == 0,
                               mark_last && j == len - 1);
                end
                messages_sent++;
            end
        end

        wait_drained();

        $display("run covered %0d input words in %0d messages under %0d register settings",
                 words_sent, messages_sent, N_SETTINGS + 1);
        $display("checked %0d head blocks and %0d keystream words", heads, stream_words);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            if (pending != 0) $display("%0d expected words never came out", pending);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/xhl_pkg.sv
rtl/xhl_in_if.sv
rtl/xhl_out_if.sv
rtl/xhl_ctrl.sv
rtl/xhl_dp.sv
rtl/xtea_head_lfsr_stream_cipher_core.sv
sim/xhl_cipher_checker.sv
sim/tb.sv
